// ===== hw/rtl/utf8d_pkg.sv =====
package utf8d_pkg;

   localparam int unsigned CP_WIDTH    = 21;
   localparam int unsigned LEN_WIDTH   = 3;
   localparam int unsigned CHAR_COUNT_WIDTH = 32;

   localparam logic [7:0] LEAD_MASK   = 8'hC0;
   localparam logic [7:0] LEN3_BIT    = 8'h20;
   localparam logic [7:0] LEN4_BIT    = 8'h10;
   localparam logic [7:0] CONT_BIT    = 8'h80;
   localparam logic [7:0] LEAD4_MASK  = 8'h07;
   localparam logic [7:0] CONT_MASK   = 8'h3F;
   localparam logic [7:0] LEAD3_MASK  = 8'h0F;
   localparam logic [7:0] LEAD2_MASK  = 8'h1F;

   localparam logic [LEN_WIDTH-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_WIDTH-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_WIDTH-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_WIDTH-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_WIDTH-1:0] LEN_FOUR = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0]         code_point;
      logic                        char_done;
      logic [LEN_WIDTH-1:0]        char_bytes;
      logic                        string_end;
      logic [CHAR_COUNT_WIDTH-1:0] char_count;
      logic                        bad_encoding;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/utf8d_in_stage.sv =====
module utf8d_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  utf8d_pkg::req_payload_type req_payload,
   input  logic                       step,
   output logic                       item_valid,
   output utf8d_pkg::req_payload_type item
);
   import utf8d_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type item_ff;
   logic            free;

   assign free      = !valid_ff || step;
   assign req_stall = !free;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && free) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && free) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/utf8d_decode.sv =====
module utf8d_decode #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  utf8d_pkg::req_payload_type item,
   output logic                       has_result,
   output utf8d_pkg::rsp_payload_type result
);
   import utf8d_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [CP_WIDTH-1:0]    partial_ff, partial_in;
   logic [LEN_WIDTH-1:0]   expected_ff, expected_in;
   logic [LEN_WIDTH-1:0]   seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   error_ff, error_in;

   logic [7:0]             b;
   logic                   done;
   logic [CP_WIDTH-1:0]    cp;
   logic [LEN_WIDTH-1:0]   nbytes;
   logic [CP_WIDTH-1:0]    shifted;
   logic [LEN_WIDTH-1:0]   seen_inc;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   error_next;
   logic [63:0]            count_wide;

   assign b        = item.data_byte;
   assign shifted  = {partial_ff[CP_WIDTH-7:0], b[5:0] & CONT_MASK[5:0]};
   assign seen_inc = seen_ff + LEN_ONE;

   always_comb begin
      partial_in  = partial_ff;
      expected_in = expected_ff;
      seen_in     = seen_ff;
      error_next  = error_ff;
      count_next  = count_ff;
      done        = 1'b0;
      cp          = '0;
      nbytes      = LEN_NONE;
      if (!error_ff) begin
         if (expected_ff == LEN_NONE) begin
            if ((b & LEAD_MASK) == LEAD_MASK) begin
               if ((b & LEN3_BIT) != 8'h00) begin
                  if ((b & LEN4_BIT) != 8'h00) begin
                     expected_in = LEN_FOUR;
                     partial_in  = CP_WIDTH'(b & LEAD4_MASK);
                  end else begin
                     expected_in = LEN_THREE;
                     partial_in  = CP_WIDTH'(b & LEAD3_MASK);
                  end
               end else begin
                  expected_in = LEN_TWO;
                  partial_in  = CP_WIDTH'(b & LEAD2_MASK);
               end
               seen_in = LEN_ONE;
            end else begin
               done   = 1'b1;
               cp     = CP_WIDTH'(b);
               nbytes = LEN_ONE;
            end
         end else if ((b & CONT_BIT) != 8'h00) begin
            if (seen_inc >= expected_ff) begin
               done        = 1'b1;
               cp          = shifted;
               nbytes      = expected_ff;
               partial_in  = '0;
               expected_in = LEN_NONE;
               seen_in     = LEN_NONE;
            end else begin
               partial_in = shifted;
               seen_in    = seen_inc;
            end
         end else begin
            error_next  = 1'b1;
            partial_in  = '0;
            expected_in = LEN_NONE;
            seen_in     = LEN_NONE;
         end
         if (done && count_ff != COUNT_MAX) begin
            count_next = count_ff + 1'b1;
         end
      end
      if (item.last_byte && expected_in != LEN_NONE) begin
         error_next = 1'b1;
      end
      count_in = count_next;
      error_in = error_next;
      if (item.last_byte) begin
         partial_in  = '0;
         expected_in = LEN_NONE;
         seen_in     = LEN_NONE;
         count_in    = '0;
         error_in    = 1'b0;
      end
   end

   assign count_wide = 64'(count_next);

   always_comb begin
      has_result          = done || item.last_byte;
      result.code_point   = cp;
      result.char_done    = done;
      result.char_bytes   = nbytes;
      result.string_end   = item.last_byte;
      result.char_count   = count_wide[CHAR_COUNT_WIDTH-1:0];
      result.bad_encoding = error_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         expected_ff <= LEN_NONE;
         seen_ff     <= LEN_NONE;
         count_ff    <= '0;
         error_ff    <= 1'b0;
      end else if (step) begin
         partial_ff  <= partial_in;
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         count_ff    <= count_in;
         error_ff    <= error_in;
      end
   end

   // sequence bookkeeping
   assert property (@(posedge clock) disable iff (reset)
      error_ff |-> expected_ff == LEN_NONE)
      else $error("error flag set with a sequence in progress");

   assert property (@(posedge clock) disable iff (reset)
      expected_ff != LEN_NONE |-> seen_ff < expected_ff && seen_ff != LEN_NONE)
      else $error("byte position out of range");

   assert property (@(posedge clock) disable iff (reset)
      expected_ff == LEN_NONE |-> seen_ff == LEN_NONE && partial_ff == '0)
      else $error("stale partial character while idle");

   assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> count_ff == '0 && expected_ff == LEN_NONE && !error_ff)
      else $error("string state not cleared after last byte");

endmodule

// ===== hw/rtl/utf8d_out_stage.sv =====
module utf8d_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  utf8d_pkg::rsp_payload_type result,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output utf8d_pkg::rsp_payload_type rsp_payload
);
   import utf8d_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   assign free = !(valid_ff && rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         payload_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// Loose UTF-8 decoder over a byte stream: one byte per transaction with a last flag.
// Each completed character gives a response with its code point and length; the last
// byte always gives a response with the saturating character count and a sticky
// invalid flag. Stray bytes 0x80-0xBF decode as themselves; after an error the count
// freezes until the end of the string. The block takes one byte per cycle: a byte sits
// in the input register, is decoded against the sequence registers and lands in the
// response register, from which the response is driven. A stalled response holds the
// input register, which then stalls requests.
module utf8_stream_decoder #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  utf8d_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output utf8d_pkg::rsp_payload_type rsp_payload
);
   import utf8d_pkg::*;

   logic            item_valid;
   req_payload_type item;
   logic            out_free;
   logic            step;
   logic            has_result;
   rsp_payload_type result;

   assign step = item_valid && out_free;

   utf8d_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .step        (step),
      .item_valid  (item_valid),
      .item        (item)
   );

   utf8d_decode #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (item),
      .has_result (has_result),
      .result     (result)
   );

   utf8d_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (step && has_result),
      .result      (result),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
